// ----- hw/rtl/blg_pkg.sv -----
// ----------------------------------------------------------------------------
// blg_pkg: battery level gauge shared definitions
// Batch sizes, arithmetic widths, level codes, register map, sequencer states
// and the request/response bundle of the shared divider.
// ----------------------------------------------------------------------------
package blg_pkg;

  localparam int SAMPLES_PER_READING = 10;
  localparam int CHIRP_HOLDOFF_MS    = 5000;
  localparam int BLINK_PERIOD_MS     = 400;
  localparam int VOLT_LIMIT_MV       = 20000;

  localparam int RAW_W     = 16;
  localparam int GAIN_W    = 18;
  localparam int MV_W      = 15;
  localparam int OFS_W     = 16;
  localparam int TIME_W    = 32;
  localparam int PADDR_W   = 5;
  localparam int IDX_W     = 3;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(SAMPLES_PER_READING + 1);
  localparam int SUM_W     = RAW_W + $clog2(SAMPLES_PER_READING);
  localparam int PROD_W    = SUM_W + GAIN_W + 1;
  localparam int TQ_W      = PROD_W + 1 - 16;
  localparam int V_W       = TQ_W + 2;
  localparam int DVS_W     = 16;
  localparam int DIV_CNT_W = $clog2(TQ_W + 1);
  localparam int BLINK_W   = $clog2(BLINK_PERIOD_MS);

  localparam logic [CNT_W-1:0]     SAMPLES_LAST = CNT_W'(SAMPLES_PER_READING - 1);
  localparam logic [BLINK_W-1:0]   BLINK_LAST   = BLINK_W'(BLINK_PERIOD_MS - 1);
  localparam logic [BLINK_W-1:0]   BLINK_HALF   = BLINK_W'(BLINK_PERIOD_MS / 2);
  localparam logic [TIME_W-1:0]    CHIRP_HOLD   = TIME_W'(CHIRP_HOLDOFF_MS);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS    = DIV_CNT_W'(TQ_W);

  localparam logic signed [V_W-1:0]  V_SAT_HI = V_W'(VOLT_LIMIT_MV);
  localparam logic signed [V_W-1:0]  V_SAT_LO = V_W'(-VOLT_LIMIT_MV);
  localparam logic signed [15:0]     OUT_V_HI = 16'(VOLT_LIMIT_MV);
  localparam logic signed [15:0]     OUT_V_LO = 16'(-VOLT_LIMIT_MV);

  localparam logic [2:0] LVL_FULL  = 3'd0;
  localparam logic [2:0] LVL_OK    = 3'd1;
  localparam logic [2:0] LVL_LOW   = 3'd2;
  localparam logic [2:0] LVL_NONE  = 3'd3;
  localparam logic [2:0] LVL_ERROR = 3'd4;

  localparam logic [IDX_W-1:0] REG_GAIN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET = 3'd1;
  localparam logic [IDX_W-1:0] REG_FULL   = 3'd2;
  localparam logic [IDX_W-1:0] REG_EMPTY  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MINV   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_DIVA_GO,
    ST_DIVA_WAIT,
    ST_OFS,
    ST_CLASS,
    ST_DIVB_GO,
    ST_DIVB_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [TQ_W-1:0]  dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TQ_W-1:0]  quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [7:0] led_bar(input logic [2:0] steps);
    led_bar = ~(8'hFE << steps);
  endfunction

endpackage

// ----- hw/rtl/blg_div.sv -----
// ----------------------------------------------------------------------------
// blg_div: shared restoring divider
// Unsigned division, one quotient bit per cycle; done pulses after the last.
// ----------------------------------------------------------------------------
module blg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  blg_pkg::div_req_t req,
  output blg_pkg::div_rsp_t rsp
);
  import blg_pkg::*;

  logic [TQ_W-1:0]      quo_r, quo_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[TQ_W-1]};
    diff     = trial - {1'b0, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = DIV_STEPS;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DVS_W]) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[TQ_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[TQ_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- hw/rtl/battery_level_gauge.sv -----
// ----------------------------------------------------------------------------
// battery_level_gauge: battery voltage gauge with LED bar and chirp flag
// Counts millisecond ticks, averages each batch of ADC samples, scales the
// mean to millivolts and classifies it; drives an LED bar and a chirp flag.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// in       request    in_valid/in_ready   in_kind, in_raw_sample, in_read_ok
// out      result     out_valid/out_ready out_voltage_mv, out_level,
//                                         out_led_pattern, out_buzz_start
// cfg      APB write  psel/penable/pready paddr, pwdata, prdata
//
// A tick or a mid-batch sample leaves in_ready high. The request that closes a
// batch holds in_ready low while the sequencer runs: two passes through the
// bit-serial divider when the level is ok, one for the other levels and none
// with no valid sample.
// A finished result waits in the output register while ticks and samples go
// on; a closing batch holds in ST_DONE until that register frees up.
// Reset is synchronous, active low, and restores the calibration defaults.
// ----------------------------------------------------------------------------
module battery_level_gauge (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic signed [blg_pkg::RAW_W-1:0] in_raw_sample,
  input  logic                            in_read_ok,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [15:0]              out_voltage_mv,
  output logic [2:0]                      out_level,
  output logic [7:0]                      out_led_pattern,
  output logic                            out_buzz_start,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [blg_pkg::PADDR_W-1:0]     paddr,
  input  logic [blg_pkg::DATA_W-1:0]      pwdata,
  output logic [blg_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import blg_pkg::*;

  logic [GAIN_W-1:0]        gain_r;
  logic signed [OFS_W-1:0]  offset_r;
  logic [MV_W-1:0]          full_r, empty_r, minv_r;
  logic [IDX_W-1:0]         reg_idx;
  logic                     cfg_wr;

  state_t                   state_r, state_nxt;
  logic [TIME_W-1:0]        time_r, time_nxt;
  logic [BLINK_W-1:0]       blink_r, blink_nxt;
  logic [TIME_W-1:0]        chirp_r, chirp_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]         vcnt_r, vcnt_nxt;
  logic [CNT_W-1:0]         acnt_r, acnt_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [TQ_W-1:0]   t_r, t_nxt;
  logic signed [V_W-1:0]    q_r, q_nxt;
  logic signed [V_W-1:0]    v_r, v_nxt;
  logic [TQ_W-1:0]          bnum_r, bnum_nxt;
  logic [DVS_W-1:0]         bden_r, bden_nxt;
  logic signed [15:0]       res_volt_r, res_volt_nxt;
  logic [2:0]               res_level_r, res_level_nxt;
  logic [7:0]               res_led_r, res_led_nxt;
  logic                     res_buzz_r, res_buzz_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [15:0]       out_volt_r, out_volt_nxt;
  logic [2:0]               out_level_r, out_level_nxt;
  logic [7:0]               out_led_r, out_led_nxt;
  logic                     out_buzz_r, out_buzz_nxt;

  logic signed [PROD_W:0]   rsum;
  logic [V_W-1:0]           qmag;
  logic signed [V_W-1:0]    full_s, empty_s, minv_s;
  logic [15:0]              span;
  logic [15:0]              vrel;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_W'(33010);
      offset_r <= OFS_W'(2670);
      full_r   <= MV_W'(12400);
      empty_r  <= MV_W'(11110);
      minv_r   <= MV_W'(6000);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GAIN:   gain_r   <= pwdata[GAIN_W-1:0];
        REG_OFFSET: offset_r <= pwdata[OFS_W-1:0];
        REG_FULL:   full_r   <= pwdata[MV_W-1:0];
        REG_EMPTY:  empty_r  <= pwdata[MV_W-1:0];
        REG_MINV:   minv_r   <= pwdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN:   prdata = DATA_W'(gain_r);
      REG_OFFSET: prdata = DATA_W'($unsigned(offset_r));
      REG_FULL:   prdata = DATA_W'(full_r);
      REG_EMPTY:  prdata = DATA_W'(empty_r);
      REG_MINV:   prdata = DATA_W'(minv_r);
      default:    prdata = '0;
    endcase
  end

  blg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign full_s  = $signed(V_W'(full_r));
  assign empty_s = $signed(V_W'(empty_r));
  assign minv_s  = $signed(V_W'(minv_r));
  assign span    = {1'b0, full_r} - {1'b0, empty_r};
  assign vrel    = 16'(v_r - empty_s);
  assign rsum    = {prod_r[PROD_W-1], prod_r} + (PROD_W+1)'({vcnt_r, 15'd0});
  assign qmag    = V_W'(div_rsp.quot) + V_W'(t_r[TQ_W-1] && (div_rsp.rem != '0));

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    time_nxt      = time_r;
    blink_nxt     = blink_r;
    chirp_nxt     = chirp_r;
    sum_nxt       = sum_r;
    vcnt_nxt      = vcnt_r;
    acnt_nxt      = acnt_r;
    prod_nxt      = prod_r;
    t_nxt         = t_r;
    q_nxt         = q_r;
    v_nxt         = v_r;
    bnum_nxt      = bnum_r;
    bden_nxt      = bden_r;
    res_volt_nxt  = res_volt_r;
    res_level_nxt = res_level_r;
    res_led_nxt   = res_led_r;
    res_buzz_nxt  = res_buzz_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_volt_nxt  = out_volt_r;
    out_level_nxt = out_level_r;
    out_led_nxt   = out_led_r;
    out_buzz_nxt  = out_buzz_r;
    div_req.start    = 1'b0;
    div_req.dividend = t_r[TQ_W-1] ? TQ_W'(-t_r) : TQ_W'(t_r);
    div_req.divisor  = DVS_W'(vcnt_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_kind) begin
            time_nxt  = time_r + 1'b1;
            blink_nxt = (blink_r == BLINK_LAST) ? '0 : blink_r + 1'b1;
          end else begin
            if (in_read_ok) begin
              sum_nxt  = sum_r + SUM_W'(in_raw_sample);
              vcnt_nxt = vcnt_r + 1'b1;
            end
            acnt_nxt = acnt_r + 1'b1;
            if (acnt_r == SAMPLES_LAST) begin
              state_nxt = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        if (vcnt_r == '0) begin
          res_volt_nxt  = '0;
          res_level_nxt = LVL_ERROR;
          res_led_nxt   = '0;
          res_buzz_nxt  = 1'b0;
          state_nxt     = ST_DONE;
        end else begin
          prod_nxt  = sum_r * $signed({1'b0, gain_r});
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        t_nxt     = rsum[PROD_W:16];
        state_nxt = ST_DIVA_GO;
      end
      ST_DIVA_GO: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIVA_WAIT;
      end
      ST_DIVA_WAIT: begin
        if (div_rsp.done) begin
          q_nxt     = t_r[TQ_W-1] ? -$signed(qmag) : $signed(qmag);
          state_nxt = ST_OFS;
        end
      end
      ST_OFS: begin
        v_nxt     = q_r + V_W'(offset_r);
        state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        res_buzz_nxt = 1'b0;
        res_led_nxt  = '0;
        if (v_r > V_SAT_HI) begin
          res_volt_nxt = OUT_V_HI;
        end else if (v_r < V_SAT_LO) begin
          res_volt_nxt = OUT_V_LO;
        end else begin
          res_volt_nxt = v_r[15:0];
        end
        state_nxt = ST_DONE;
        if (v_r[V_W-1]) begin
          res_level_nxt = LVL_ERROR;
        end else if (v_r >= full_s) begin
          res_level_nxt = LVL_FULL;
          res_led_nxt   = 8'hFF;
        end else if (v_r >= empty_s) begin
          res_level_nxt = LVL_OK;
          bnum_nxt      = (TQ_W'(vrel) << 4) - (TQ_W'(vrel) << 1) + TQ_W'(span);
          bden_nxt      = {span[14:0], 1'b0};
          state_nxt     = ST_DIVB_GO;
        end else begin
          res_level_nxt = (v_r >= minv_s) ? LVL_LOW : LVL_NONE;
          res_led_nxt   = {7'd0, blink_r < BLINK_HALF};
          if ((v_r >= minv_s) && ((time_r - chirp_r) >= CHIRP_HOLD)) begin
            res_buzz_nxt = 1'b1;
            chirp_nxt    = time_r;
          end
        end
      end
      ST_DIVB_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = bnum_r;
        div_req.divisor  = bden_r;
        state_nxt        = ST_DIVB_WAIT;
      end
      ST_DIVB_WAIT: begin
        if (div_rsp.done) begin
          res_led_nxt = led_bar(div_rsp.quot[2:0]);
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_volt_nxt  = res_volt_r;
          out_level_nxt = res_level_r;
          out_led_nxt   = res_led_r;
          out_buzz_nxt  = res_buzz_r;
          sum_nxt       = '0;
          vcnt_nxt      = '0;
          acnt_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_r      <= '0;
      blink_r     <= '0;
      chirp_r     <= '0;
      sum_r       <= '0;
      vcnt_r      <= '0;
      acnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      blink_r     <= blink_nxt;
      chirp_r     <= chirp_nxt;
      sum_r       <= sum_nxt;
      vcnt_r      <= vcnt_nxt;
      acnt_r      <= acnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r      <= prod_nxt;
    t_r         <= t_nxt;
    q_r         <= q_nxt;
    v_r         <= v_nxt;
    bnum_r      <= bnum_nxt;
    bden_r      <= bden_nxt;
    res_volt_r  <= res_volt_nxt;
    res_level_r <= res_level_nxt;
    res_led_r   <= res_led_nxt;
    res_buzz_r  <= res_buzz_nxt;
    out_volt_r  <= out_volt_nxt;
    out_level_r <= out_level_nxt;
    out_led_r   <= out_led_nxt;
    out_buzz_r  <= out_buzz_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_voltage_mv  = out_volt_r;
  assign out_level       = out_level_r;
  assign out_led_pattern = out_led_r;
  assign out_buzz_start  = out_buzz_r;

  a_vcnt_le_acnt: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= acnt_r)
    else $error("valid sample count exceeds attempt count");

  a_batch_open: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> acnt_r <= SAMPLES_LAST)
    else $error("batch overran while idle");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIVA_WAIT || state_r == ST_DIVB_WAIT))
    else $error("divider finished outside a wait state");

  a_error_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_level_r == LVL_ERROR |-> out_led_r == '0 && !out_buzz_r)
    else $error("read error result with lit bar or chirp");

  a_buzz_low_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_buzz_r |-> out_level_r == LVL_LOW)
    else $error("chirp on a level other than low");

endmodule

// ----- tb/sv/blg_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// blg_tb_pkg: battery level gauge testbench codes
// Request kind codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package blg_tb_pkg;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ADC  = 1'b1;

endpackage

// ----- tb/sv/blg_checker.sv -----
// ----------------------------------------------------------------------------
// blg_checker: battery level gauge scoreboard
// Watches the request, result and APB ports, keeps its own copy of the
// calibration registers and batch state, predicts each batch reading and
// compares every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module blg_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               in_kind,
  input  logic signed [blg_pkg::RAW_W-1:0]   in_raw_sample,
  input  logic                               in_read_ok,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [15:0]                 out_voltage_mv,
  input  logic [2:0]                         out_level,
  input  logic [7:0]                         out_led_pattern,
  input  logic                               out_buzz_start,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [blg_pkg::PADDR_W-1:0]        paddr,
  input  logic [blg_pkg::DATA_W-1:0]         pwdata,
  input  logic                               pready,
  output int                                 fail_count,
  output int                                 due_count,
  output int                                 reading_count
);
  import blg_pkg::*;
  import blg_tb_pkg::*;

  typedef struct {
    logic signed [15:0] voltage_mv;
    logic [2:0]         level;
    logic [7:0]         led_pattern;
    logic               buzz_start;
  } gauge_reading_t;

  gauge_reading_t readings_due[$];

  logic [GAIN_W-1:0]        gain_q;
  logic signed [OFS_W-1:0]  offset_q;
  logic [MV_W-1:0]          full_q;
  logic [MV_W-1:0]          empty_q;
  logic [MV_W-1:0]          minv_q;

  logic [TIME_W-1:0]        ms_count;
  logic [TIME_W-1:0]        chirp_stamp;
  logic [8:0]               blink_cnt;
  longint                   batch_sum;
  int                       n_valid;
  int                       n_tries;

  initial begin
    fail_count    = 0;
    due_count     = 0;
    reading_count = 0;
  end

  function automatic gauge_reading_t grade_batch();
    gauge_reading_t    r;
    longint            den;
    longint            num;
    longint            q;
    longint            v;
    longint            vs;
    longint            d;
    longint            steps;
    logic [TIME_W-1:0] elapsed;
    r.voltage_mv  = '0;
    r.level       = LVL_ERROR;
    r.led_pattern = '0;
    r.buzz_start  = 1'b0;
    if (n_valid != 0) begin
      den = longint'(n_valid) * 65536;
      num = batch_sum * longint'(gain_q) + den / 2;
      q = num / den;
      if (num < 0 && q * den != num) q = q - 1;
      v = q + longint'(offset_q);
      vs = v;
      if (vs > VOLT_LIMIT_MV) vs = VOLT_LIMIT_MV;
      if (vs < -VOLT_LIMIT_MV) vs = -VOLT_LIMIT_MV;
      r.voltage_mv = 16'(vs);
      if (v >= 0) begin
        if (v >= longint'(full_q)) begin
          r.level       = LVL_FULL;
          r.led_pattern = 8'hFF;
        end else if (v >= longint'(empty_q)) begin
          d = longint'(full_q) - longint'(empty_q);
          steps = (14 * (v - longint'(empty_q)) + d) / (2 * d);
          if (steps > 7) steps = 7;
          if (steps < 0) steps = 0;
          r.level       = LVL_OK;
          r.led_pattern = 8'((longint'(1) <<< (steps + 1)) - 1);
        end else begin
          r.level = (v >= longint'(minv_q)) ? LVL_LOW : LVL_NONE;
          r.led_pattern = (int'(blink_cnt) < BLINK_PERIOD_MS / 2) ? 8'd1 : 8'd0;
          elapsed = ms_count - chirp_stamp;
          if (r.level == LVL_LOW && elapsed >= TIME_W'(CHIRP_HOLDOFF_MS)) begin
            chirp_stamp  = ms_count;
            r.buzz_start = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    gauge_reading_t want;
    if (!rst_n) begin
      gain_q      = GAIN_W'(33010);
      offset_q    = OFS_W'(2670);
      full_q      = MV_W'(12400);
      empty_q     = MV_W'(11110);
      minv_q      = MV_W'(6000);
      ms_count    = '0;
      chirp_stamp = '0;
      blink_cnt   = '0;
      batch_sum   = 0;
      n_valid     = 0;
      n_tries     = 0;
      readings_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_GAIN:   gain_q   = pwdata[GAIN_W-1:0];
          REG_OFFSET: offset_q = pwdata[OFS_W-1:0];
          REG_FULL:   full_q   = pwdata[MV_W-1:0];
          REG_EMPTY:  empty_q  = pwdata[MV_W-1:0];
          REG_MINV:   minv_q   = pwdata[MV_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_TICK) begin
          ms_count++;
          blink_cnt = (int'(blink_cnt) == BLINK_PERIOD_MS - 1) ? 9'd0 : blink_cnt + 9'd1;
        end else begin
          if (in_read_ok) begin
            batch_sum += longint'(in_raw_sample);
            n_valid++;
          end
          n_tries++;
          if (n_tries >= SAMPLES_PER_READING) begin
            readings_due.push_back(grade_batch());
            batch_sum = 0;
            n_valid   = 0;
            n_tries   = 0;
          end
        end
      end
      if (out_valid && out_ready) begin
        reading_count++;
        if (readings_due.size() == 0) begin
          $error("unexpected result: voltage_mv %0d level %0d", out_voltage_mv, out_level);
          fail_count++;
        end else begin
          want = readings_due.pop_front();
          check_field("voltage_mv", want.voltage_mv, out_voltage_mv);
          check_field("level", {29'd0, want.level}, {29'd0, out_level});
          check_field("led_pattern", {24'd0, want.led_pattern}, {24'd0, out_led_pattern});
          check_field("buzz_start", {31'd0, want.buzz_start}, {31'd0, out_buzz_start});
        end
      end
    end
    due_count = readings_due.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: battery level gauge testbench
// Drives ticks and ADC conversion requests in batches aimed at each battery
// level, under several calibration settings and idle mixes on both channels.
// The checker predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import blg_pkg::*;
  import blg_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 100;
  localparam int N_PHASES     = 8;
  localparam int N_BATCHES    = 5;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_kind;
  logic signed [RAW_W-1:0]   in_raw_sample;
  logic                      in_read_ok;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [15:0]        out_voltage_mv;
  logic [2:0]                out_level;
  logic [7:0]                out_led_pattern;
  logic                      out_buzz_start;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  int fail_count;
  int due_count;
  int reading_count;
  int cycle_count = 0;
  int n_reqs      = 0;
  int n_settings  = 0;
  int tx_idle     = 0;
  int rx_stall    = 0;

  int cur_gain;
  int cur_ofs;
  int cur_full;
  int cur_empty;
  int cur_minv;

  battery_level_gauge dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_raw_sample   (in_raw_sample),
    .in_read_ok      (in_read_ok),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_voltage_mv  (out_voltage_mv),
    .out_level       (out_level),
    .out_led_pattern (out_led_pattern),
    .out_buzz_start  (out_buzz_start),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  blg_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_raw_sample   (in_raw_sample),
    .in_read_ok      (in_read_ok),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_voltage_mv  (out_voltage_mv),
    .out_level       (out_level),
    .out_led_pattern (out_led_pattern),
    .out_buzz_start  (out_buzz_start),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .due_count       (due_count),
    .reading_count   (reading_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall);
  end

  task automatic send_req(input logic kind, input logic signed [RAW_W-1:0] raw,
                          input logic ok);
    logic rdy;
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_raw_sample <= raw;
    in_read_ok    <= ok;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    n_reqs++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_req(KIND_TICK, RAW_W'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    logic rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (due_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input int g, input int o, input int f, input int e,
                                input int m);
    write_reg(REG_GAIN, DATA_W'(g));
    write_reg(REG_OFFSET, DATA_W'(o));
    write_reg(REG_FULL, DATA_W'(f));
    write_reg(REG_EMPTY, DATA_W'(e));
    write_reg(REG_MINV, DATA_W'(m));
    cur_gain  = g;
    cur_ofs   = o;
    cur_full  = f;
    cur_empty = e;
    cur_minv  = m;
    n_settings++;
  endtask

  function automatic int clamp_raw(input longint r);
    if (r > 32767) return 32767;
    if (r < -32768) return -32768;
    return int'(r);
  endfunction

  function automatic int raw_for_mv(input int target);
    if (cur_gain == 0) return int'($urandom_range(0, 65535)) - 32768;
    return clamp_raw(((longint'(target) - cur_ofs) * 65536) / cur_gain);
  endfunction

  function automatic int pick_target_mv();
    int r;
    r = $urandom_range(99);
    if (r < 20) return cur_full + int'($urandom_range(0, 600)) - 300;
    if (r < 45) return int'($urandom_range(cur_empty, cur_full));
    if (r < 70) return int'($urandom_range(cur_minv, cur_empty));
    if (r < 80) return int'($urandom_range(0, cur_minv));
    if (r < 90) return -int'($urandom_range(1, 20000));
    return int'($urandom_range(0, 45000)) - 22500;
  endfunction

  task automatic run_batch();
    int  center;
    int  r;
    int  n;
    bit  wild;
    bit  all_fail;
    center   = raw_for_mv(pick_target_mv());
    wild     = ($urandom_range(99) < 20);
    all_fail = ($urandom_range(99) < 5);
    for (int i = 0; i < SAMPLES_PER_READING; i++) begin
      r = $urandom_range(99);
      n = (r < 70) ? 0 : (r < 95) ? int'($urandom_range(1, 2)) : int'($urandom_range(3, 12));
      send_ticks(n);
      send_req(KIND_ADC,
               wild ? RAW_W'($urandom)
                    : RAW_W'(clamp_raw(center + int'($urandom_range(0, 128)) - 64)),
               !all_fail && ($urandom_range(99) >= 15));
    end
  endtask

  task automatic pick_settings(input int phase);
    int lo;
    int hi;
    int m;
    case (phase)
      0: apply_settings(33010, 2670, 12400, 11110, 6000);
      1: apply_settings(262143, -20000, 20000, 0, 0);
      2: apply_settings(0, 20000, 20000, 0, 20000);
      3: apply_settings(50000, 0, 8000, 12000, 10000);
      4: apply_settings(40000, 1000, 9001, 9000, 3000);
      default: begin
        lo = $urandom_range(0, 20000);
        hi = $urandom_range(0, 20000);
        m  = $urandom_range(0, 20000);
        if (lo > hi && $urandom_range(99) < 80) begin
          lo = lo ^ hi;
          hi = lo ^ hi;
          lo = lo ^ hi;
        end
        apply_settings($urandom_range(0, 262143), int'($urandom_range(0, 40000)) - 20000,
                       hi, lo, (m < lo) ? m : lo / 2);
      end
    endcase
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= KIND_TICK;
    in_raw_sample <= '0;
    in_read_ok    <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: extremes, all-failed batch, max/min samples
    send_ticks(2);
    for (int i = 0; i < SAMPLES_PER_READING; i++)
      send_req(KIND_ADC, (i % 2) ? 16'sh8000 : 16'sh7FFF, 1'b0);
    for (int i = 0; i < SAMPLES_PER_READING; i++)
      send_req(KIND_ADC, (i < SAMPLES_PER_READING / 2) ? 16'sh7FFF : 16'sh8000, 1'b1);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle = 0;  rx_stall = 0;  end
        1: begin tx_idle = 76; rx_stall = 0;  end
        2: begin tx_idle = 0;  rx_stall = 76; end
        default: begin tx_idle = 34; rx_stall = 34; end
      endcase
      pick_settings(p);
      for (int b = 0; b < N_BATCHES; b++) begin
        run_batch();
      end
      drain();
    end

    $display("Run covered %0d requests and %0d batch readings over %0d register settings,",
             n_reqs, reading_count, n_settings);
    $display("with idle and stall mixes on both channels.");
    if (fail_count == 0 && due_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/blg_pkg.sv
hw/rtl/blg_div.sv
hw/rtl/battery_level_gauge.sv
tb/sv/blg_tb_pkg.sv
tb/sv/blg_checker.sv
tb/sv/tb_top.sv
